[hdl/mf3_pkg.sv]
// Shared constants and types for the 3x3 median filter.
// Used by the top level and the checker; depends on nothing else.
package mf3_pkg;

   // Default sizing handed to the top-level parameters.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int PIXEL_BITS_DEF = 8;

   // Control and status register port.
   localparam int CSR_BITS     = 11;
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
   localparam logic [CSR_BITS-1:0]     DIM_RESET        = 11'd1024;

   // Row and column fields of a result.
   localparam int POS_BITS = 10;

   // Result queue between the pipeline and the response port.
   localparam int FIFO_DEPTH     = 16;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;
   localparam int RES_BITS       = FIFO_CNT_BITS + 1;
   localparam int MAX_RESULTS    = 3;

   // Which results one pixel produces and where they sit in the frame.
   typedef struct packed {
      logic                has_a;   // interior or edge pixel of the row above
      logic                a_med;   // that pixel takes the median
      logic                has_b;   // last column of the row above
      logic                has_c;   // pass-through of the arriving pixel
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } meta_type;

endpackage

[hdl/mf3_ram.sv]
// Generic simple dual-port RAM with a registered read port.
// Self-contained; used for the line buffers of the median filter.
module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mf3_median.sv]
// Two-stage median-of-nine compare-exchange network.
// Uses no package items; instantiated by the median_filter_3x3 top level.
module mf3_median #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                       clock,
   input  logic [8:0][PIXEL_BITS-1:0] win_in,
   output logic [PIXEL_BITS-1:0]      med_out
);

   logic [8:0][PIXEL_BITS-1:0] half_in;
   logic [8:0][PIXEL_BITS-1:0] half_ff;
   logic [8:0][PIXEL_BITS-1:0] full_in;
   logic [PIXEL_BITS-1:0]      med_ff;

   function automatic logic [8:0][PIXEL_BITS-1:0] cmp_exch(
      input logic [8:0][PIXEL_BITS-1:0] v,
      input int                         a,
      input int                         b
   );
      logic [8:0][PIXEL_BITS-1:0] r;
      r = v;
      if (v[a] > v[b]) begin
         r[a] = v[b];
         r[b] = v[a];
      end
      return r;
   endfunction

   // First five layers: sort each triple, then merge across triples.
   always_comb begin
      half_in = win_in;
      half_in = cmp_exch(half_in, 1, 2);
      half_in = cmp_exch(half_in, 4, 5);
      half_in = cmp_exch(half_in, 7, 8);
      half_in = cmp_exch(half_in, 0, 1);
      half_in = cmp_exch(half_in, 3, 4);
      half_in = cmp_exch(half_in, 6, 7);
      half_in = cmp_exch(half_in, 1, 2);
      half_in = cmp_exch(half_in, 4, 5);
      half_in = cmp_exch(half_in, 7, 8);
      half_in = cmp_exch(half_in, 0, 3);
      half_in = cmp_exch(half_in, 5, 8);
      half_in = cmp_exch(half_in, 4, 7);
      half_in = cmp_exch(half_in, 3, 6);
      half_in = cmp_exch(half_in, 1, 4);
      half_in = cmp_exch(half_in, 2, 5);
   end

   // Last four layers settle the middle element.
   always_comb begin
      full_in = half_ff;
      full_in = cmp_exch(full_in, 4, 7);
      full_in = cmp_exch(full_in, 2, 4);
      full_in = cmp_exch(full_in, 4, 6);
      full_in = cmp_exch(full_in, 2, 4);
   end

   always_ff @(posedge clock) begin
      half_ff <= half_in;
      med_ff  <= full_in[4];
   end

   assign med_out = med_ff;

endmodule

[hdl/median_filter_3x3.sv]
// 3x3 median filter over a raster pixel stream.
// Depends on mf3_pkg, mf3_ram (line buffers) and mf3_median (sorting network).
//
// Usage:
//   Pixels enter on the req_ channel in raster order, one transaction each.
//   Results leave on the rsp_ channel with their row and column; run_last
//   marks the final result caused by one input pixel (up to three results).
//   Rows 0 and height-1 pass through as they arrive. Any other pixel leaves
//   when its lower-right neighbor (last column: the one below) arrives: border
//   columns unchanged, interior pixels as the median of their 3x3 window.
//   image_width and image_height are written through csr_ while idle.
// A pass-through result moves through the pipeline stages and then the result queue to reach rsp_.
// Throughput: one pixel per cycle while results are taken as fast as they are
//   made; in the last row most pixels make two results, so there the response
//   port limits the pixel rate. Each pixel in flight holds three places in a
//   16-entry result queue, and req_stall rises when the queue cannot take
//   another three.
// Reset: counters go to row 0, column 0, both dimensions to 1024, the queue
//   empties. Line buffers are not cleared and hold garbage until written.
// A stalled result stays on rsp_ unchanged; the queue absorbs the pipeline.
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [PIXEL_BITS-1:0]             req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [PIXEL_BITS-1:0]             rsp_pixel_out,
   output logic [mf3_pkg::POS_BITS-1:0]      rsp_out_row,
   output logic [mf3_pkg::POS_BITS-1:0]      rsp_out_col,
   output logic                              rsp_run_last,
   input  logic                              csr_we,
   input  logic [mf3_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mf3_pkg::CSR_BITS-1:0]      csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DIM_A = (mf3_pkg::CSR_BITS > CW + 1) ? mf3_pkg::CSR_BITS : CW + 1;
   localparam int DIM_BITS = (DIM_A > RW + 1) ? DIM_A : RW + 1;
   localparam logic [DIM_BITS-1:0] MAXW_D = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] MAXH_D = DIM_BITS'(MAX_HEIGHT);
   localparam int PB = PIXEL_BITS;
   localparam int FP = mf3_pkg::FIFO_PTR_BITS;
   localparam int FC = mf3_pkg::FIFO_CNT_BITS;
   localparam int RB = mf3_pkg::RES_BITS;
   localparam int PS = mf3_pkg::POS_BITS;

   // Configuration registers.
   logic [mf3_pkg::CSR_BITS-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::DIM_RESET;
         height_ff <= mf3_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mf3_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            mf3_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective dimensions: zero acts as one, large values saturate.
   logic [DIM_BITS-1:0] w_ext, h_ext, dim_w, dim_h;
   logic [CW-1:0]       w_last;
   logic [RW-1:0]       h_last;

   always_comb begin
      w_ext  = DIM_BITS'(width_ff);
      h_ext  = DIM_BITS'(height_ff);
      dim_w  = (width_ff == '0) ? DIM_BITS'(1) : ((w_ext > MAXW_D) ? MAXW_D : w_ext);
      dim_h  = (height_ff == '0) ? DIM_BITS'(1) : ((h_ext > MAXH_D) ? MAXH_D : h_ext);
      w_last = CW'(dim_w - DIM_BITS'(1));
      h_last = RW'(dim_h - DIM_BITS'(1));
   end

   // Position counters and acceptance.
   logic [CW-1:0]     col_ff, col_in, acc_col;
   logic [RW-1:0]     row_ff, row_in, acc_row;
   logic [RW:0]       row_step;
   logic              col_wrap, row_wrap, accept;
   mf3_pkg::meta_type acc_meta;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [FC-1:0]     count_ff, count_in;
   logic [1:0]        in_flight;
   logic [RB-1:0]     reserve;

   always_comb begin
      in_flight = 2'(s1_valid_ff) + 2'(s2_valid_ff) + 2'(s3_valid_ff);
      reserve   = RB'(count_ff) + RB'(in_flight) * RB'(mf3_pkg::MAX_RESULTS)
                  + RB'(mf3_pkg::MAX_RESULTS);
   end

   assign req_stall = reserve > RB'(mf3_pkg::FIFO_DEPTH);
   assign accept    = req_valid && !req_stall;

   // A shrunk width or height since the last pixel moves it to the next row or frame.
   always_comb begin
      col_wrap = DIM_BITS'(col_ff) >= dim_w;
      row_step = col_wrap ? ({1'b0, row_ff} + (RW + 1)'(1)) : {1'b0, row_ff};
      row_wrap = DIM_BITS'(row_step) >= dim_h;
      acc_row  = row_wrap ? '0 : row_step[RW-1:0];
      acc_col  = col_wrap ? '0 : col_ff;
      if (acc_col == w_last) begin
         col_in = '0;
         row_in = (acc_row == h_last) ? '0 : acc_row + RW'(1);
      end else begin
         col_in = acc_col + CW'(1);
         row_in = acc_row;
      end
      acc_meta.has_a = (acc_row >= RW'(2)) && (acc_col != '0);
      acc_meta.a_med = acc_col != CW'(1);
      acc_meta.has_b = (acc_row >= RW'(2)) && (acc_col == w_last);
      acc_meta.has_c = (acc_row == '0) || (acc_row == h_last);
      acc_meta.row   = PS'(acc_row);
      acc_meta.col   = PS'(acc_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: line buffer data arrives; window shifts; line buffer write-back.
   logic [2*PB-1:0]   lb_rd_data, lb_wr_data;
   logic [PB-1:0]     s1_pix_ff;
   logic [CW-1:0]     s1_col_ff;
   mf3_pkg::meta_type s1_meta_ff;
   logic              s1_fwd_ff;
   logic [2*PB-1:0]   s1_fwd_word_ff;
   logic [2*PB-1:0]   s1_word;
   logic [PB-1:0]     up_px, mid_px;
   logic [PB-1:0]     win_ff [6];
   logic [8:0][PB-1:0] win_vals;

   always_comb begin
      s1_word    = s1_fwd_ff ? s1_fwd_word_ff : lb_rd_data;
      up_px      = s1_word[2*PB-1:PB];
      mid_px     = s1_word[PB-1:0];
      lb_wr_data = {mid_px, s1_pix_ff};
      win_vals[0] = win_ff[0];
      win_vals[1] = win_ff[3];
      win_vals[2] = up_px;
      win_vals[3] = win_ff[1];
      win_vals[4] = win_ff[4];
      win_vals[5] = mid_px;
      win_vals[6] = win_ff[2];
      win_vals[7] = win_ff[5];
      win_vals[8] = s1_pix_ff;
   end

   // The entry being read is the one stage 1 writes now only when the width is one.
   mf3_ram #(
      .WIDTH (2 * PB),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (lb_wr_data),
      .rd_addr (acc_col),
      .rd_data (lb_rd_data)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_pixel_in;
         s1_col_ff      <= acc_col;
         s1_meta_ff     <= acc_meta;
         s1_fwd_ff      <= s1_valid_ff && (s1_col_ff == acc_col);
         s1_fwd_word_ff <= lb_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Stages 2 and 3 carry the side results alongside the sorting network.
   logic [PB-1:0]     med_px;
   mf3_pkg::meta_type s2_meta_ff, s3_meta_ff;
   logic [PB-1:0]     s2_a_ff, s2_b_ff, s2_c_ff, s3_a_ff, s3_b_ff, s3_c_ff;

   mf3_median #(
      .PIXEL_BITS (PB)
   ) u_median (
      .clock   (clock),
      .win_in  (win_vals),
      .med_out (med_px)
   );

   always_ff @(posedge clock) begin
      s2_meta_ff <= s1_meta_ff;
      s2_a_ff    <= win_ff[4];
      s2_b_ff    <= mid_px;
      s2_c_ff    <= s1_pix_ff;
      s3_meta_ff <= s2_meta_ff;
      s3_a_ff    <= s2_a_ff;
      s3_b_ff    <= s2_b_ff;
      s3_c_ff    <= s2_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Result queue: stage 3 writes up to three entries in one cycle.
   logic [PB-1:0] fifo_pix_ff  [mf3_pkg::FIFO_DEPTH];
   logic [PS-1:0] fifo_row_ff  [mf3_pkg::FIFO_DEPTH];
   logic [PS-1:0] fifo_col_ff  [mf3_pkg::FIFO_DEPTH];
   logic          fifo_last_ff [mf3_pkg::FIFO_DEPTH];
   logic [FP-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FP-1:0] slot_a, slot_b, slot_c;
   logic [1:0]    push_cnt;
   logic          push_a, push_b, push_c, pop;
   logic [PB-1:0] res_a;
   logic [PS-1:0] row_up, col_left;

   always_comb begin
      push_a   = s3_valid_ff && s3_meta_ff.has_a;
      push_b   = s3_valid_ff && s3_meta_ff.has_b;
      push_c   = s3_valid_ff && s3_meta_ff.has_c;
      push_cnt = 2'(push_a) + 2'(push_b) + 2'(push_c);
      slot_a   = wr_ptr_ff;
      slot_b   = wr_ptr_ff + FP'(push_a);
      slot_c   = wr_ptr_ff + FP'(push_a) + FP'(push_b);
      res_a    = s3_meta_ff.a_med ? med_px : s3_a_ff;
      row_up   = s3_meta_ff.row - PS'(1);
      col_left = s3_meta_ff.col - PS'(1);
      pop      = rsp_valid && !rsp_stall;
      wr_ptr_in = wr_ptr_ff + FP'(push_cnt);
      rd_ptr_in = rd_ptr_ff + FP'(pop);
      count_in  = count_ff + FC'(push_cnt) - FC'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         fifo_pix_ff[slot_a]  <= res_a;
         fifo_row_ff[slot_a]  <= row_up;
         fifo_col_ff[slot_a]  <= col_left;
         fifo_last_ff[slot_a] <= !s3_meta_ff.has_b && !s3_meta_ff.has_c;
      end
      if (push_b) begin
         fifo_pix_ff[slot_b]  <= s3_b_ff;
         fifo_row_ff[slot_b]  <= row_up;
         fifo_col_ff[slot_b]  <= s3_meta_ff.col;
         fifo_last_ff[slot_b] <= !s3_meta_ff.has_c;
      end
      if (push_c) begin
         fifo_pix_ff[slot_c]  <= s3_c_ff;
         fifo_row_ff[slot_c]  <= s3_meta_ff.row;
         fifo_col_ff[slot_c]  <= s3_meta_ff.col;
         fifo_last_ff[slot_c] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid     = count_ff != '0;
   assign rsp_pixel_out = fifo_pix_ff[rd_ptr_ff];
   assign rsp_out_row   = fifo_row_ff[rd_ptr_ff];
   assign rsp_out_col   = fifo_col_ff[rd_ptr_ff];
   assign rsp_run_last  = fifo_last_ff[rd_ptr_ff];

endmodule

[hdl/mf3_checker.sv]
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg for port widths.
module mf3_checker #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [PIXEL_BITS-1:0]            req_pixel_in,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [PIXEL_BITS-1:0]            rsp_pixel_out,
   input logic [mf3_pkg::POS_BITS-1:0]     rsp_out_row,
   input logic [mf3_pkg::POS_BITS-1:0]     rsp_out_col,
   input logic                             rsp_run_last,
   input logic                             csr_we,
   input logic [mf3_pkg::CSR_IDX_BITS-1:0] csr_index,
   input logic [mf3_pkg::CSR_BITS-1:0]     csr_wdata
);

   // A stalled result holds its payload.
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_pixel_out, rsp_out_row, rsp_out_col, rsp_run_last}))
      else $error("stalled result changed");

   // Reset empties the result queue.
   rsp_reset_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Right after reset the block must take a pixel.
   req_reset_a: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   // The results of one pixel are queued together, so a run never breaks up.
   run_whole_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("gap inside a run of results");

endmodule

bind median_filter_3x3 mf3_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_mf3_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_pixel_in  (req_pixel_in),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_run_last  (rsp_run_last),
   .csr_we        (csr_we),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);
